@@ rtl/pet_pkg.sv @@
package pet_pkg;

   localparam int TAP_BUTTONS = 6;

   // Bit positions of the tracked buttons (masks 0x10, 0x40, 0x80, 0x20, 0x400, 0x800)
   localparam logic [3:0] TAP_BIT [TAP_BUTTONS] = '{4'd4, 4'd6, 4'd7, 4'd5, 4'd10, 4'd11};
   localparam logic [15:0] TAP_MASK_ALL = 16'h0CF0;

   localparam logic [7:0] KIND_ABSENT      = 8'hFF;
   localparam logic [7:0] TAP_WINDOW_RESET = 8'd6;

   typedef enum logic [1:0] {
      TAP_IDLE  = 2'd0,
      TAP_ARMED = 2'd1,
      TAP_PULSE = 2'd2
   } tap_phase_type;

   typedef struct packed {
      logic        pad_absent;
      logic [7:0]  pad_id;
      logic [15:0] raw_buttons;
      logic [31:0] analog_word;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  pad_kind;
      logic [15:0] held;
      logic [15:0] held_before;
      logic [15:0] pressed;
      logic [15:0] released;
      logic [15:0] double_tap;
      logic [31:0] analog_out;
   } rsp_word_type;

endpackage

@@ rtl/pad_edge_and_double_tap.sv @@
// Gamepad poll front end: edge detection and double-tap detection.
//
// Request channel (req_valid / req_stall / req_word): one poll word per frame.
// A word is taken at a rising edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_word): one result word per poll,
// in poll order, showing the pad state after that poll has been applied.
// Configuration (csr_wr_en / csr_wr_data): sets tap_window, the number of armed
// frames counted before a pending first tap expires (window is tap_window + 1).
//
// A result word is registered into the output stage when its poll is taken.
// Throughput: one word per cycle while rsp_stall is low. All per-poll work is a
// single pass of small logic from the state registers into the result register;
// the six tap machines run side by side. A two-entry output stage (result register
// plus skid register) lets a poll be taken while the previous result still waits.
// req_stall comes from a register and reset only, so it never depends on rsp_stall.
//
// Reset (synchronous, active high): clear all pad state, idle the tap machines,
// load tap_window with 6, empty the output stage and hold req_stall high.
// When the receiver stalls, the held result stays steady on rsp_word; one more
// poll is taken into the skid register, then req_stall rises until it drains.
module pad_edge_and_double_tap (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pet_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pet_pkg::rsp_word_type rsp_word,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import pet_pkg::*;

   // pad state
   logic [7:0]    window_ff;
   logic [7:0]    kind_ff,     kind_in;
   logic [15:0]   held_ff,     held_in;
   logic [15:0]   prev_in;
   logic [15:0]   pressed_ff,  pressed_in;
   logic [15:0]   released_ff, released_in;
   logic [15:0]   latch_ff,    latch_in;
   logic [31:0]   analog_in;
   tap_phase_type phase_ff [TAP_BUTTONS];
   tap_phase_type phase_in [TAP_BUTTONS];
   logic [7:0]    count_ff [TAP_BUTTONS];
   logic [7:0]    count_in [TAP_BUTTONS];
   logic [TAP_BUTTONS-1:0] press_hit;
   logic [TAP_BUTTONS-1:0] expire;

   // output stage
   logic          out_valid_ff;
   rsp_word_type  out_ff;
   logic          skid_valid_ff;
   rsp_word_type  skid_ff;
   rsp_word_type  result;

   logic          accept;
   logic          pop;

   // Stall while the skid register is occupied, and throughout reset.
   assign req_stall = skid_valid_ff | reset;
   assign accept    = req_valid & ~req_stall;
   assign pop       = out_valid_ff & ~rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // Edge words. An absent pad clears the live words but keeps released.
   always_comb begin
      if (req_word.pad_absent) begin
         kind_in     = KIND_ABSENT;
         held_in     = '0;
         prev_in     = '0;
         pressed_in  = '0;
         released_in = released_ff;
         analog_in   = '0;
      end else begin
         kind_in     = {4'd0, req_word.pad_id[7:4]};
         held_in     = ~req_word.raw_buttons;
         prev_in     = held_ff;
         pressed_in  = held_in & ~held_ff;
         released_in = held_ff & ~held_in;
         analog_in   = req_word.analog_word;
      end
   end

   // A fresh press counts only when the button's pulse is not showing.
   always_comb begin
      for (int k = 0; k < TAP_BUTTONS; k++) begin
         press_hit[k] = ~latch_ff[TAP_BIT[k]] & pressed_in[TAP_BIT[k]];
         expire[k]    = count_ff[k] >= window_ff;
      end
   end

   // Tap machines: next phase.
   always_comb begin
      for (int k = 0; k < TAP_BUTTONS; k++) begin
         phase_in[k] = phase_ff[k];
         if (!req_word.pad_absent) begin
            if (press_hit[k]) begin
               phase_in[k] = (phase_ff[k] == TAP_IDLE) ? TAP_ARMED : TAP_PULSE;
            end else begin
               unique case (phase_ff[k])
                  TAP_IDLE: begin
                     phase_in[k] = TAP_IDLE;
                  end
                  TAP_PULSE: begin
                     phase_in[k] = TAP_IDLE;
                  end
                  default: begin
                     if (expire[k]) phase_in[k] = TAP_IDLE;
                  end
               endcase
            end
         end
      end
   end

   // Tap machines: window count and pulse bits.
   always_comb begin
      latch_in = latch_ff;
      for (int k = 0; k < TAP_BUTTONS; k++) begin
         count_in[k] = count_ff[k];
         if (!req_word.pad_absent) begin
            if (press_hit[k]) begin
               count_in[k] = '0;
               if (phase_ff[k] != TAP_IDLE) latch_in[TAP_BIT[k]] = 1'b1;
            end else begin
               unique case (phase_ff[k])
                  TAP_IDLE: begin
                     count_in[k] = count_ff[k];
                  end
                  TAP_PULSE: begin
                     latch_in[TAP_BIT[k]] = 1'b0;
                  end
                  default: begin
                     count_in[k] = count_ff[k] + 8'd1;
                     if (expire[k]) latch_in[TAP_BIT[k]] = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      result.pad_kind    = kind_in;
      result.held        = held_in;
      result.held_before = prev_in;
      result.pressed     = pressed_in;
      result.released    = released_in;
      result.double_tap  = latch_in;
      result.analog_out  = analog_in;
   end

   // Advance pad state on each accepted word; a CSR write loads the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= TAP_WINDOW_RESET;
         kind_ff     <= '0;
         held_ff     <= '0;
         pressed_ff  <= '0;
         released_ff <= '0;
         latch_ff    <= '0;
         for (int k = 0; k < TAP_BUTTONS; k++) begin
            phase_ff[k] <= TAP_IDLE;
            count_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) window_ff <= csr_wr_data;
         if (accept) begin
            kind_ff     <= kind_in;
            held_ff     <= held_in;
            pressed_ff  <= pressed_in;
            released_ff <= released_in;
            latch_ff    <= latch_in;
            for (int k = 0; k < TAP_BUTTONS; k++) begin
               phase_ff[k] <= phase_in[k];
               count_ff[k] <= count_in[k];
            end
         end
      end
   end

   // Output stage: result register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

`ifndef SYNTHESIS
   // The skid register only fills behind a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word with the result register empty");

   // Double-tap pulses appear only on tracked buttons.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.double_tap & ~TAP_MASK_ALL) == 16'd0))
      else $error("double-tap bit outside the tracked buttons");

   // A button cannot be pressed and released in the same frame.
   assert property (@(posedge clock) disable iff (reset)
      (pressed_ff & released_ff) == 16'd0)
      else $error("pressed and released overlap");

   // An absent pad reports the absent kind.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.pad_absent) |=> (kind_ff == KIND_ABSENT))
      else $error("absent pad did not report the absent kind");

   // A double-tap pulse lasts one present frame only.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_word.pad_absent) |=> ((latch_ff & $past(latch_ff)) == 16'd0))
      else $error("double-tap pulse held past one frame");
`endif

endmodule

@@ tb/sv/tb_pad_edge_and_double_tap.sv @@
module tb_pad_edge_and_double_tap;

   import pet_pkg::*;

   // Pad state tracker: mirrors the poll logic of the block and keeps the
   // result words still to come back, oldest first.
   class pad_state_tracker;
      logic [7:0]    window;
      logic [7:0]    kind;
      logic [15:0]   held;
      logic [15:0]   held_prev;
      logic [15:0]   pressed;
      logic [15:0]   released;
      logic [15:0]   taps;
      logic [31:0]   analog;
      tap_phase_type tap_state [TAP_BUTTONS];
      logic [7:0]    tap_cnt [TAP_BUTTONS];
      rsp_word_type  results_due [$];
      int            errors;
      int            polls;
      int            absent_polls;
      int            pulse_polls;
      int            checked;

      function new();
         window = TAP_WINDOW_RESET;
         kind = '0;
         held = '0;
         held_prev = '0;
         pressed = '0;
         released = '0;
         taps = '0;
         analog = '0;
         for (int k = 0; k < TAP_BUTTONS; k++) begin
            tap_state[k] = TAP_IDLE;
            tap_cnt[k] = '0;
         end
         errors = 0;
         polls = 0;
         absent_polls = 0;
         pulse_polls = 0;
         checked = 0;
      endfunction

      function void set_window(logic [7:0] value);
         window = value;
      endfunction

      function void step_tap(int k);
         logic [15:0] m;
         logic [7:0]  c;
         m = 16'd1 << TAP_BIT[k];
         if ((taps & m) == 16'd0 && (pressed & m) != 16'd0) begin
            tap_cnt[k] = '0;
            if (tap_state[k] == TAP_IDLE) begin
               tap_state[k] = TAP_ARMED;
            end else begin
               tap_state[k] = TAP_PULSE;
               taps = taps | m;
            end
            return;
         end
         if (tap_state[k] == TAP_IDLE)
            return;
         if (tap_state[k] != TAP_PULSE) begin
            c = tap_cnt[k];
            tap_cnt[k] = c + 8'd1;
            if (c < window)
               return;
         end
         tap_state[k] = TAP_IDLE;
         taps = taps & ~m;
      endfunction

      function void take_poll(req_word_type w);
         rsp_word_type want;
         polls++;
         if (w.pad_absent) begin
            absent_polls++;
            kind = KIND_ABSENT;
            held = '0;
            held_prev = '0;
            pressed = '0;
            analog = '0;
         end else begin
            kind = {4'd0, w.pad_id[7:4]};
            held_prev = held;
            analog = w.analog_word;
            held = ~w.raw_buttons;
            pressed = held & ~held_prev;
            released = held_prev & ~held;
            for (int k = 0; k < TAP_BUTTONS; k++)
               step_tap(k);
         end
         if (taps != 16'd0)
            pulse_polls++;
         want.pad_kind = kind;
         want.held = held;
         want.held_before = held_prev;
         want.pressed = pressed;
         want.released = released;
         want.double_tap = taps;
         want.analog_out = analog;
         results_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_report(rsp_word_type got);
         rsp_word_type want;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, got %h", $time, got);
            return;
         end
         want = results_due.pop_front();
         checked++;
         compare_field("pad_kind", 32'(want.pad_kind), 32'(got.pad_kind));
         compare_field("held", 32'(want.held), 32'(got.held));
         compare_field("held_before", 32'(want.held_before), 32'(got.held_before));
         compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
         compare_field("released", 32'(want.released), 32'(got.released));
         compare_field("double_tap", 32'(want.double_tap), 32'(got.double_tap));
         compare_field("analog_out", want.analog_out, got.analog_out);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;

   // Set to hold both sides busy for a whole phase with no idling at all.
   logic         no_gaps = 1'b0;

   // Buttons the stimulus means to have down, active high, as the block sees them.
   logic [15:0]  pad_held = '0;

   pad_state_tracker pads = new();

   always #1 clock = ~clock;

   pad_edge_and_double_tap dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Receiver: stall at random on the falling edge, check on the rising edge.
   // Values read straight after the rising edge are those from before it.
   always @(negedge clock)
      rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 36);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         pads.check_report(rsp_word);
   end

   // Offer one poll word and hold it until taken. Entered and left just after
   // a falling edge; valid is left high so a following word goes out with no gap.
   task automatic send_poll(input req_word_type w);
      while (!no_gaps && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do
         @(posedge clock);
      while (req_stall);
      pads.take_poll(w);
      @(negedge clock);
   endtask

   // Present pad with the given buttons down; id and analog bytes at random.
   task automatic send_held(input logic [15:0] buttons);
      req_word_type w;
      w.pad_absent = 1'b0;
      w.pad_id = 8'($urandom());
      w.raw_buttons = ~buttons;
      w.analog_word = $urandom();
      pad_held = buttons;
      send_poll(w);
   endtask

   // No pad: every other field is junk and must be ignored.
   task automatic send_absent();
      req_word_type w;
      w.pad_absent = 1'b1;
      w.pad_id = 8'($urandom());
      w.raw_buttons = 16'($urandom());
      w.analog_word = $urandom();
      pad_held = '0;
      send_poll(w);
   endtask

   // Random polls: tracked buttons flip with the given odds, untracked bits
   // churn freely, with an occasional absent pad or a fully random word.
   task automatic run_polls(input int n, input int toggle_pct, input int absent_pct,
                            input int noise_pct);
      logic [15:0] buttons;
      repeat (n) begin
         if ($urandom_range(0, 99) < absent_pct) begin
            send_absent();
         end else if ($urandom_range(0, 99) < noise_pct) begin
            send_held(16'($urandom()));
         end else begin
            buttons = pad_held & TAP_MASK_ALL;
            for (int k = 0; k < TAP_BUTTONS; k++) begin
               if ($urandom_range(0, 99) < toggle_pct)
                  buttons[TAP_BIT[k]] = ~buttons[TAP_BIT[k]];
            end
            send_held(buttons | (16'($urandom()) & ~TAP_MASK_ALL));
         end
      end
   endtask

   // Tap every tracked button, leave them up for `gap` polls, then tap again.
   // The second tap lands inside the window when gap is no more than tap_window.
   task automatic tap_stretch(input int gap);
      send_held(16'($urandom()) & ~TAP_MASK_ALL);
      send_held(TAP_MASK_ALL | (16'($urandom()) & ~TAP_MASK_ALL));
      repeat (gap)
         send_held(16'($urandom()) & ~TAP_MASK_ALL);
      send_held(TAP_MASK_ALL | (16'($urandom()) & ~TAP_MASK_ALL));
   endtask

   // Drop valid, let every result drain, then write the window register.
   task automatic write_window(input logic [7:0] value);
      req_valid <= 1'b0;
      while (pads.results_due.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pads.set_window(value);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed polls under the reset window of 6.
      send_held(16'h0000);                      // all up
      send_poll('{1'b0, 8'h00, 16'h0000, 32'hFFFF_FFFF});   // every button down: arm all
      send_poll('{1'b0, 8'h3C, 16'hFFFF, 32'h0000_0000});   // all up, count once
      send_held(TAP_MASK_ALL);                  // second tap: pulse all six
      send_absent();                            // absent while pulsing: hold taps
      send_held(TAP_MASK_ALL);                  // pressed in the frame after: clear
      send_held(16'h0000);
      send_held(16'h0010);                      // arm one button
      repeat (7) send_held(16'h0000);           // window runs out on the seventh
      send_held(16'h0010);                      // fresh arm, not a double tap
      send_held(16'h0000);
      send_absent();
      send_held(16'h0010);                      // absent frame between taps still counts
      send_held(16'hF30F);                      // untracked buttons only
      send_absent();

      // Zero window: a double tap only gets through with an absent poll between.
      write_window(8'd0);
      run_polls(200, 40, 10, 8);
      run_polls(2, 0, 0, 0);                    // let every machine fall idle

      // Widest windows: probe both sides of the expiry boundary.
      write_window(8'd254);
      tap_stretch(255);                         // one poll too late
      run_polls(100, 10, 5, 5);
      write_window(8'd0);
      run_polls(2, 0, 0, 0);
      write_window(8'd255);
      tap_stretch(255);                         // last poll of a 256-frame window
      run_polls(100, 10, 5, 5);

      // Back to the default with both sides flat out.
      write_window(TAP_WINDOW_RESET);
      no_gaps = 1'b1;
      run_polls(200, 30, 5, 8);
      no_gaps = 1'b0;

      repeat (3) begin
         write_window(8'($urandom_range(1, 12)));
         run_polls(60, 25, 8, 8);
      end

      // Drain: wait for the last result, then for any stragglers.
      req_valid <= 1'b0;
      while (pads.results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Covered %0d polls (%0d with no pad) and %0d result words, %0d showing a tap pulse,",
               pads.polls, pads.absent_polls, pads.checked, pads.pulse_polls);
      $display("across tap windows 0, 6, 254, 255 and three small random ones.");
      if (pads.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
